// File: hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared types and constants for the key-value cache with LRU replacement.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int CAP_W  = 5;
	localparam int DATA_W = 32;

	localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
	localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_SET = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] key;
		logic [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] value;
	} lookup_t;

endpackage

// File: hdl/lkvc_table.sv
// ----------------------------------------------------------------------------
// LRU key-value cache table
// Entry storage with parallel key compare, recency rank update and fill count.
// ----------------------------------------------------------------------------
module lkvc_table import lkvc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  req_t             req,
	input  logic [CAP_W-1:0] capacity,
	output lookup_t          lookup
);

	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [DATA_W-1:0] key_q   [ENTRIES];
	logic [DATA_W-1:0] value_q [ENTRIES];
	logic [RANK_W-1:0] rank_q  [ENTRIES];
	logic [CNT_W-1:0]  filled_q;

	logic [ENTRIES-1:0] filled;
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] victim;
	logic [ENTRIES-1:0] sel;
	logic [DATA_W-1:0]  hit_value;
	logic [RANK_W-1:0]  hit_rank;
	logic               hit;
	logic [CMP_W-1:0]   eff_cap;
	logic               fill_ok;
	logic [CNT_W-1:0]   old_rank;
	logic               is_set;
	logic               touch;

	always_comb begin
		hit_value = '0;
		hit_rank  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			filled[i] = CNT_W'(i) < filled_q;
			match[i]  = filled[i] && (key_q[i] == req.key);
			victim[i] = filled[i] && (CNT_W'(rank_q[i]) == filled_q - CNT_W'(1));
			if (match[i]) begin
				hit_value = hit_value | value_q[i];
				hit_rank  = hit_rank | rank_q[i];
			end
		end
		hit = |match;

		// A capacity of zero acts as one; above the table size it saturates.
		if (capacity == '0) begin
			eff_cap = CMP_W'(1);
		end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = CMP_W'(capacity);
		end
		fill_ok = CMP_W'(filled_q) < eff_cap;

		// The least recent entry always holds rank filled-1, so a fill acts
		// like touching an entry of rank filled.
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit) begin
				sel[i] = match[i];
			end else if (fill_ok) begin
				sel[i] = CNT_W'(i) == filled_q;
			end else begin
				sel[i] = victim[i];
			end
		end
		if (hit) begin
			old_rank = CNT_W'(hit_rank);
		end else if (fill_ok) begin
			old_rank = filled_q;
		end else begin
			old_rank = filled_q - CNT_W'(1);
		end

		is_set = req.op == OP_SET;
		touch  = req_valid && (is_set || hit);

		lookup.hit   = hit;
		lookup.value = hit ? hit_value : MISS_VALUE;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (touch) begin
				if (sel[i]) begin
					rank_q[i] <= '0;
				end else if (filled[i] && (CNT_W'(rank_q[i]) < old_rank)) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
			if (req_valid && is_set && sel[i]) begin
				key_q[i]   <= req.key;
				value_q[i] <= req.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (req_valid && is_set && !hit && fill_ok) begin
			filled_q <= filled_q + CNT_W'(1);
		end
	end

endmodule

// File: hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Channel   Signals                           Transfer
// request   start, busy, operation/key/value  start high, busy low
// result    done, hit, read_value             done high, one cycle
// config    cfg_valid, cfg_ready, cfg_data    cfg_valid and cfg_ready high
//
// One request is taken every cycle; busy stays low.
// A get's result shows on done once the request and result registers have been
// loaded; a set gives no result.
// The compare, rank update and write of an entry happen in the cycle after
// the request is registered, so the next request sees the new state.
// Reset empties the table and sets the capacity to 16; the result side has
// no stall.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkvc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     operation,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CAP_W-1:0]         cfg_data,
	output logic                     done,
	output logic                     hit,
	output logic signed [DATA_W-1:0] read_value
);

	logic             valid_s1;
	req_t             req_s1;
	logic [CAP_W-1:0] cap_q;
	lookup_t          lookup;
	logic             done_s2;
	logic             hit_s2;
	logic [DATA_W-1:0] read_value_s2;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1.op    <= op_t'(operation);
			req_s1.key   <= key;
			req_s1.value <= value;
		end
	end

	lkvc_table #(
		.ENTRIES(ENTRIES)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(valid_s1),
		.req      (req_s1),
		.capacity (cap_q),
		.lookup   (lookup)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1 && (req_s1.op == OP_GET);
		end
	end

	always_ff @(posedge clk) begin
		hit_s2        <= lookup.hit;
		read_value_s2 <= lookup.value;
	end

	assign done       = done_s2;
	assign hit        = hit_s2;
	assign read_value = read_value_s2;

endmodule

// File: bench/tb_lru_key_value_cache.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key-value cache testbench
// Drives gets and sets with random gaps through several capacity settings and
// checks every lookup result against a behavioral copy of the LRU table.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache import lkvc_pkg::*;;

	localparam int ENTRIES       = 16;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 1000;
	localparam int PHASE_ITEMS   = 192;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     operation;
	logic signed [DATA_W-1:0] key;
	logic signed [DATA_W-1:0] value;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CAP_W-1:0]         cfg_data;
	logic                     done;
	logic                     hit;
	logic signed [DATA_W-1:0] read_value;

	// Behavioral copy of the table.
	logic [DATA_W-1:0] model_keys   [ENTRIES];
	logic [DATA_W-1:0] model_values [ENTRIES];
	logic [3:0]        model_rank   [ENTRIES];
	logic [CAP_W-1:0]  model_filled;
	logic [CAP_W-1:0]  model_capacity;

	lookup_t pending_lookups[$];
	int      failures;
	bit      gaps_enabled;

	lru_key_value_cache #(.ENTRIES(ENTRIES)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.done       (done),
		.hit        (hit),
		.read_value (read_value)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Entry idx becomes the newest; every filled entry newer than it ages by one.
	function automatic void promote_entry(int idx);
		logic [3:0] old_rank;
		old_rank = model_rank[idx];
		for (int i = 0; i < model_filled; i++) begin
			if (model_rank[i] < old_rank)
				model_rank[i] = model_rank[i] + 4'd1;
		end
		model_rank[idx] = 4'd0;
	endfunction

	function automatic void cache_model_apply(op_t op, logic [DATA_W-1:0] k,
		logic [DATA_W-1:0] v);
		int      found;
		int      victim;
		int      limit;
		lookup_t res;
		found = -1;
		for (int i = 0; i < model_filled; i++) begin
			if (found < 0 && model_keys[i] == k)
				found = i;
		end
		limit = model_capacity;
		if (limit == 0)
			limit = 1;
		if (limit > ENTRIES)
			limit = ENTRIES;

		if (op == OP_GET) begin
			if (found >= 0) begin
				promote_entry(found);
				res.hit   = 1'b1;
				res.value = model_values[found];
			end else begin
				res.hit   = 1'b0;
				res.value = MISS_VALUE;
			end
			pending_lookups.push_back(res);
		end else if (found >= 0) begin
			model_values[found] = v;
			promote_entry(found);
		end else if (model_filled < limit) begin
			for (int i = 0; i < model_filled; i++)
				model_rank[i] = model_rank[i] + 4'd1;
			model_keys[model_filled]   = k;
			model_values[model_filled] = v;
			model_rank[model_filled]   = 4'd0;
			model_filled = model_filled + 1'b1;
		end else begin
			// The oldest filled entry is replaced; this also covers a capacity
			// lowered below the current fill level.
			victim = 0;
			for (int i = 1; i < model_filled; i++) begin
				if (model_rank[i] > model_rank[victim])
					victim = i;
			end
			model_keys[victim]   = k;
			model_values[victim] = v;
			promote_entry(victim);
		end
	endfunction

	task automatic send_request(op_t op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
		int roll;
		int gap;
		gap = 0;
		if (gaps_enabled) begin
			roll = $urandom_range(0, 99);
			if (roll >= 92)
				gap = $urandom_range(8, 30);
			else if (roll >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		key       <= k;
		value     <= v;
		do @(posedge clk); while (busy);
		cache_model_apply(op, k, v);
	endtask

	// Stop sending and let every outstanding lookup and table write finish.
	task automatic settle_idle();
		start <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		model_capacity = cap;
	endtask

	task automatic test_empty_lookups();
		gaps_enabled = 1'b0;
		send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'h8000_0000);
	endtask

	task automatic test_update_and_hit();
		write_capacity(5'd16);
		gaps_enabled = 1'b1;
		send_request(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
		send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(OP_SET, 32'h0000_0000, 32'h1234_5678);
		send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
	endtask

	task automatic test_capacity_corners();
		// Zero acts as one, and it lies below the current fill level.
		write_capacity(5'd0);
		send_request(OP_SET, 32'h0000_0011, 32'hA5A5_A5A5);
		send_request(OP_SET, 32'h0000_0022, 32'h5A5A_5A5A);
		send_request(OP_GET, 32'h0000_0011, 32'h0000_0000);
		send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
		// Values above the table size saturate to the full table.
		write_capacity(5'd31);
		send_request(OP_SET, 32'h0000_0033, 32'h0F0F_0F0F);
		send_request(OP_GET, 32'h0000_0033, 32'h0000_0000);
		write_capacity(5'd17);
		send_request(OP_SET, 32'h0000_0044, 32'hF0F0_F0F0);
		send_request(OP_GET, 32'h0000_0044, 32'h0000_0000);
	endtask

	task automatic test_random_traffic();
		logic [CAP_W-1:0]  phase_caps [10];
		logic [DATA_W-1:0] key_pool   [24];
		logic [DATA_W-1:0] k;
		int                pool_size;
		int                set_percent;
		op_t               op;
		phase_caps = '{5'd1, 5'd16, 5'd2, 5'd5, 5'd31, 5'd0, 5'd8, 5'd3, 5'd17, 5'd12};
		for (int phase = 0; phase < 10; phase++) begin
			write_capacity(phase_caps[phase]);
			gaps_enabled = (phase % 4) != 1;
			pool_size    = $urandom_range(1, 24);
			set_percent  = $urandom_range(30, 70);
			for (int i = 0; i < pool_size; i++)
				key_pool[i] = $urandom;
			if (pool_size > 2) begin
				key_pool[0] = 32'h8000_0000;
				key_pool[1] = 32'h7FFF_FFFF;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, pool_size - 1)];
				else
					k = $urandom;
				op = ($urandom_range(0, 99) < set_percent) ? OP_SET : OP_GET;
				send_request(op, k, $urandom);
			end
		end
	endtask

	always @(posedge clk) begin : check_results
		lookup_t want;
		if (arst_n && done) begin
			if (pending_lookups.size() == 0) begin
				$error("result with no lookup waiting: hit=%0b read_value=%h",
					hit, read_value);
				failures++;
			end else begin
				want = pending_lookups.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0b, actual %0b", want.hit, hit);
					failures++;
				end
				if (read_value !== want.value) begin
					$error("read_value: expected %h, actual %h", want.value, read_value);
					failures++;
				end
			end
		end
	end

	// Ends the run when no request, result or register write moves for too long.
	initial begin : watchdog
		int stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("lru_key_value_cache test failed");
		$finish;
	end

	initial begin
		arst_n         <= 1'b0;
		start          <= 1'b0;
		operation      <= 1'b0;
		key            <= '0;
		value          <= '0;
		cfg_valid      <= 1'b0;
		cfg_data       <= '0;
		failures       = 0;
		gaps_enabled   = 1'b0;
		model_filled   = '0;
		model_capacity = CAP_RESET;
		for (int i = 0; i < ENTRIES; i++) begin
			model_keys[i]   = '0;
			model_values[i] = '0;
			model_rank[i]   = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lookups();
		test_update_and_hit();
		test_capacity_corners();
		test_random_traffic();
		settle_idle();

		if (failures == 0)
			$display("lru_key_value_cache test passed");
		else
			$display("lru_key_value_cache test failed");
		$finish;
	end

endmodule
